// ----- rtl/core/owbm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_pkg: shared types and constants of the single-wire bus master
// Request codes, register indexes, drive and status codes, and the structs
// passed between the request front end, the slot sequencer and the top level.
// ----------------------------------------------------------------------------
package owbm_pkg;

   localparam int BITS_PER_BYTE   = 8;
   localparam int TIMER_W         = 20;
   localparam int REQ_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   // request codes
   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_RESET      = 3'd1;
   localparam logic [2:0] OP_WRITE_BYTE = 3'd2;
   localparam logic [2:0] OP_READ_BYTE  = 3'd3;
   localparam logic [2:0] OP_WRITE_BIT  = 3'd4;
   localparam logic [2:0] OP_READ_BIT   = 3'd5;
   localparam logic [2:0] OP_PULLUP     = 3'd6;

   // register indexes
   localparam logic [2:0] CSR_RESET_LOW_TIME    = 3'd0;
   localparam logic [2:0] CSR_PRESENCE_WAIT     = 3'd1;
   localparam logic [2:0] CSR_RESET_RECOVERY    = 3'd2;
   localparam logic [2:0] CSR_SLOT_START_TIME   = 3'd3;
   localparam logic [2:0] CSR_READ_SAMPLE_DELAY = 3'd4;
   localparam logic [2:0] CSR_READ_TAIL_TIME    = 3'd5;
   localparam logic [2:0] CSR_WRITE_SLOT_TIME   = 3'd6;
   localparam logic [2:0] CSR_PULLUP_TIME       = 3'd7;

   // line drive codes
   localparam logic [1:0] DRIVE_RELEASE = 2'd0;
   localparam logic [1:0] DRIVE_LOW     = 2'd1;
   localparam logic [1:0] DRIVE_HIGH    = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_NO_PRESENCE = 2'd1;
   localparam logic [1:0] STATUS_REJECTED    = 2'd2;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_CMD,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [2:0] op;
      logic [7:0] tx_data;
      logic       line_level;
   } item_type;

   typedef struct packed {
      logic [9:0]  reset_low_time;
      logic [7:0]  presence_wait;
      logic [9:0]  reset_recovery;
      logic [3:0]  slot_start_time;
      logic [5:0]  read_sample_delay;
      logic [7:0]  read_tail_time;
      logic [7:0]  write_slot_time;
      logic [19:0] pullup_time;
   } cfg_type;

   typedef struct packed {
      logic [1:0] line_drive;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] rx_data;
   } rsp_type;

endpackage

// ----- rtl/core/owbm_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_queue: small first-in first-out queue
// Register-based queue with a full and an empty flag; the head entry is
// visible while empty is low.
// ----------------------------------------------------------------------------
module owbm_queue #(
   parameter int DEPTH = owbm_pkg::REQ_QUEUE_DEPTH,
   parameter int WIDTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/owbm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_front: request front end
// Sorts each request into tick, command or no-op and queues it for the
// slot sequencer.
// ----------------------------------------------------------------------------
module owbm_front #(
   parameter int QUEUE_DEPTH = owbm_pkg::REQ_QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [2:0]         req_type,
   input  logic [7:0]         req_tx_data,
   input  logic               req_line_level,
   output logic               item_valid,
   output owbm_pkg::item_type item,
   input  logic               item_take
);

   owbm_pkg::item_type new_item;
   logic               queue_empty;
   logic [$bits(owbm_pkg::item_type)-1:0] head_bits;

   always_comb begin
      new_item.op         = req_type;
      new_item.tx_data    = req_tx_data;
      new_item.line_level = req_line_level;
      case (req_type) inside
         owbm_pkg::OP_TICK:                        new_item.kind = owbm_pkg::KIND_TICK;
         [owbm_pkg::OP_RESET:owbm_pkg::OP_PULLUP]: new_item.kind = owbm_pkg::KIND_CMD;
         default:                                  new_item.kind = owbm_pkg::KIND_NOP;
      endcase
   end

   owbm_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(owbm_pkg::item_type))
   ) u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (new_item),
      .full      (req_full),
      .pop       (item_take),
      .pop_data  (head_bits),
      .empty     (queue_empty)
   );

   assign item       = owbm_pkg::item_type'(head_bits);
   assign item_valid = !queue_empty;

endmodule

// ----- rtl/core/owbm_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owbm_seq: slot sequencer
// Runs reset, write, read and pull-up phases one tick at a time, builds one
// response for every queued request and queues it for the response side.
// ----------------------------------------------------------------------------
module owbm_seq (
   input  logic               clock,
   input  logic               reset,
   input  owbm_pkg::cfg_type  cfg,
   input  logic               item_valid,
   input  owbm_pkg::item_type item,
   output logic               item_take,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output owbm_pkg::rsp_type  rsp
);

   localparam int TW = owbm_pkg::TIMER_W;
   localparam logic [3:0] BYTE_BITS = 4'(owbm_pkg::BITS_PER_BYTE);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_PRES_WAIT,
      PH_RST_RECOV,
      PH_SLOT_LOW,
      PH_WRITE_HOLD,
      PH_READ_WAIT,
      PH_READ_TAIL,
      PH_PULLUP
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [2:0]       op_ff, op_in;
   logic [TW-1:0]    timer_ff, timer_in, timer_dec;
   logic [3:0]       bit_ff, bit_in, bit_count;
   logic [7:0]       tx_ff, tx_in;
   logic [7:0]       rx_ff, rx_in;

   logic [TW-1:0]    pres_wait_t, slot_low_t, read_wait_t;
   logic             step, fin;
   logic [1:0]       fin_status;
   logic             is_write, op_is_read;
   owbm_pkg::rsp_type rsp_new;
   logic             rsp_full;
   logic [$bits(owbm_pkg::rsp_type)-1:0] rsp_bits;

   // zero sample waits and a zero slot start time count as one tick
   assign pres_wait_t = (cfg.presence_wait == '0) ? TW'(1) : TW'(cfg.presence_wait);
   assign slot_low_t  = (cfg.slot_start_time == '0) ? TW'(1) : TW'(cfg.slot_start_time);
   assign read_wait_t = (cfg.read_sample_delay == '0) ? TW'(1)
                                                      : TW'(cfg.read_sample_delay);

   assign is_write  = (op_ff == owbm_pkg::OP_WRITE_BYTE) || (op_ff == owbm_pkg::OP_WRITE_BIT);
   assign bit_count = ((op_ff == owbm_pkg::OP_WRITE_BYTE) || (op_ff == owbm_pkg::OP_READ_BYTE))
                      ? BYTE_BITS : 4'd1;
   assign timer_dec = (timer_ff != '0) ? timer_ff - 1'b1 : '0;

   assign item_take = item_valid && !rsp_full;

   always_comb begin
      phase_in   = phase_ff;
      op_in      = op_ff;
      timer_in   = timer_ff;
      bit_in     = bit_ff;
      tx_in      = tx_ff;
      rx_in      = rx_ff;
      step       = 1'b0;
      fin        = 1'b0;
      fin_status = owbm_pkg::STATUS_OK;
      rsp_new    = '0;

      if (item_take) begin
         case (item.kind)
            owbm_pkg::KIND_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  timer_in = timer_dec;
                  if (timer_dec == '0) begin
                     case (phase_ff)
                        PH_RST_LOW: begin
                           phase_in = PH_PRES_WAIT;
                           timer_in = pres_wait_t;
                        end
                        PH_PRES_WAIT: begin
                           if (item.line_level) begin
                              fin        = 1'b1;
                              fin_status = owbm_pkg::STATUS_NO_PRESENCE;
                           end else if (cfg.reset_recovery == '0) begin
                              fin = 1'b1;
                           end else begin
                              phase_in = PH_RST_RECOV;
                              timer_in = TW'(cfg.reset_recovery);
                           end
                        end
                        PH_RST_RECOV, PH_PULLUP: fin = 1'b1;
                        PH_SLOT_LOW: begin
                           if (!is_write) begin
                              phase_in = PH_READ_WAIT;
                              timer_in = read_wait_t;
                           end else if (cfg.write_slot_time == '0) begin
                              step = 1'b1;
                           end else begin
                              phase_in = PH_WRITE_HOLD;
                              timer_in = TW'(cfg.write_slot_time);
                           end
                        end
                        PH_READ_WAIT: begin
                           if (item.line_level && !bit_ff[3]) begin
                              rx_in = rx_ff | (8'd1 << bit_ff[2:0]);
                           end
                           if (cfg.read_tail_time == '0) begin
                              step = 1'b1;
                           end else begin
                              phase_in = PH_READ_TAIL;
                              timer_in = TW'(cfg.read_tail_time);
                           end
                        end
                        PH_WRITE_HOLD, PH_READ_TAIL: step = 1'b1;
                        default: begin
                           phase_in = PH_IDLE;
                           timer_in = '0;
                        end
                     endcase
                  end
               end
            end
            owbm_pkg::KIND_CMD: begin
               if (phase_ff != PH_IDLE) begin
                  rsp_new.status = owbm_pkg::STATUS_REJECTED;
               end else begin
                  op_in  = item.op;
                  bit_in = '0;
                  tx_in  = item.tx_data;
                  rx_in  = '0;
                  case (item.op)
                     owbm_pkg::OP_RESET: begin
                        if (cfg.reset_low_time == '0) begin
                           phase_in = PH_PRES_WAIT;
                           timer_in = pres_wait_t;
                        end else begin
                           phase_in = PH_RST_LOW;
                           timer_in = TW'(cfg.reset_low_time);
                        end
                     end
                     owbm_pkg::OP_PULLUP: begin
                        if (cfg.pullup_time == '0) begin
                           fin = 1'b1;
                        end else begin
                           phase_in = PH_PULLUP;
                           timer_in = cfg.pullup_time;
                        end
                     end
                     default: begin
                        phase_in = PH_SLOT_LOW;
                        timer_in = slot_low_t;
                     end
                  endcase
               end
            end
            default: ;
         endcase
      end

      // advance to the next bit slot, or finish after the last one
      if (step) begin
         tx_in  = tx_ff >> 1;
         bit_in = bit_ff + 1'b1;
         if (bit_in >= bit_count) begin
            fin = 1'b1;
         end else begin
            phase_in = PH_SLOT_LOW;
            timer_in = slot_low_t;
         end
      end

      op_is_read = (op_in == owbm_pkg::OP_READ_BYTE) || (op_in == owbm_pkg::OP_READ_BIT);
      if (fin) begin
         phase_in         = PH_IDLE;
         timer_in         = '0;
         rsp_new.done_res = 1'b1;
         rsp_new.status   = fin_status;
         rsp_new.rx_data  = ((fin_status == owbm_pkg::STATUS_OK) && op_is_read) ? rx_in : '0;
      end

      case (phase_in)
         PH_RST_LOW, PH_SLOT_LOW: rsp_new.line_drive = owbm_pkg::DRIVE_LOW;
         PH_WRITE_HOLD: rsp_new.line_drive = tx_in[0] ? owbm_pkg::DRIVE_HIGH
                                                      : owbm_pkg::DRIVE_LOW;
         PH_PULLUP:     rsp_new.line_drive = owbm_pkg::DRIVE_HIGH;
         default:       rsp_new.line_drive = owbm_pkg::DRIVE_RELEASE;
      endcase
      rsp_new.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         op_ff    <= '0;
         timer_ff <= '0;
         bit_ff   <= '0;
         tx_ff    <= '0;
         rx_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         timer_ff <= timer_in;
         bit_ff   <= bit_in;
         tx_ff    <= tx_in;
         rx_ff    <= rx_in;
      end
   end

   owbm_queue #(
      .DEPTH (owbm_pkg::RSP_QUEUE_DEPTH),
      .WIDTH ($bits(owbm_pkg::rsp_type))
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_take),
      .push_data (rsp_new),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_bits),
      .empty     (rsp_empty)
   );

   assign rsp = owbm_pkg::rsp_type'(rsp_bits);

endmodule

// ----- rtl/core/one_wire_bus_master.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master: single-wire bus master
// Reset with presence detect, byte and bit write and read slots, and a
// strong pull-up, paced by one tick request per microsecond.
//
// Usage:
//   Request side is a queue: push an item while full is low. A tick request
//   (type 0) carries the sampled line level and advances the running phase by
//   one microsecond; the other types start an operation and are answered with
//   status rejected while one is already running.
//   Response side is a queue: every request yields exactly one response, in
//   order, shown while empty is low and taken with pop. line_drive is the
//   drive to apply until the next tick.
//   An accepted push is registered in the request queue, and its response in
//   the response queue before it shows; one request per cycle is sustained
//   while the response side keeps popping.
//   A stalled response side fills the response queue and then the request
//   queue, after which full rises; nothing is dropped.
//   Synchronous reset empties both queues, idles the sequencer and loads the
//   register defaults. Registers are written through csr_valid/csr_ready
//   (always ready) only while idle: a user rule the block does not enforce.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
   parameter int REQ_QUEUE_DEPTH = owbm_pkg::REQ_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_tx_data,
   input  logic        req_line_level,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_line_drive,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_rx_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   owbm_pkg::cfg_type  cfg_ff, cfg_in;
   owbm_pkg::item_type item;
   owbm_pkg::rsp_type  rsp;
   logic               item_valid, item_take;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            owbm_pkg::CSR_RESET_LOW_TIME:    cfg_in.reset_low_time    = csr_wdata[9:0];
            owbm_pkg::CSR_PRESENCE_WAIT:     cfg_in.presence_wait     = csr_wdata[7:0];
            owbm_pkg::CSR_RESET_RECOVERY:    cfg_in.reset_recovery    = csr_wdata[9:0];
            owbm_pkg::CSR_SLOT_START_TIME:   cfg_in.slot_start_time   = csr_wdata[3:0];
            owbm_pkg::CSR_READ_SAMPLE_DELAY: cfg_in.read_sample_delay = csr_wdata[5:0];
            owbm_pkg::CSR_READ_TAIL_TIME:    cfg_in.read_tail_time    = csr_wdata[7:0];
            owbm_pkg::CSR_WRITE_SLOT_TIME:   cfg_in.write_slot_time   = csr_wdata[7:0];
            owbm_pkg::CSR_PULLUP_TIME:       cfg_in.pullup_time       = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_time    <= 10'd480;
         cfg_ff.presence_wait     <= 8'd60;
         cfg_ff.reset_recovery    <= 10'd420;
         cfg_ff.slot_start_time   <= 4'd2;
         cfg_ff.read_sample_delay <= 6'd15;
         cfg_ff.read_tail_time    <= 8'd50;
         cfg_ff.write_slot_time   <= 8'd120;
         cfg_ff.pullup_time       <= 20'd750000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   owbm_front #(
      .QUEUE_DEPTH (REQ_QUEUE_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_type       (req_type),
      .req_tx_data    (req_tx_data),
      .req_line_level (req_line_level),
      .item_valid     (item_valid),
      .item           (item),
      .item_take      (item_take)
   );

   owbm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp        (rsp)
   );

   assign rsp_line_drive = rsp.line_drive;
   assign rsp_busy_res   = rsp.busy_res;
   assign rsp_done_res   = rsp.done_res;
   assign rsp_status     = rsp.status;
   assign rsp_rx_data    = rsp.rx_data;

   // a finished operation leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_done_res) |-> !rsp_busy_res)
      else $error("done reported while still busy");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_done_res) |-> (rsp_status != owbm_pkg::STATUS_REJECTED))
      else $error("rejected status reported with done");

   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_done_res) |-> (rsp_rx_data == 8'd0))
      else $error("read data without done");

   // an idle master never drives the line
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_busy_res) |-> (rsp_line_drive == owbm_pkg::DRIVE_RELEASE))
      else $error("line driven while idle");

endmodule
